FILE: src/gppr_pkg.sv
// Shared constants and types for the ground plane pixel remap block.
`default_nettype none
package gppr_pkg;
  localparam int CW        = 12;
  localparam int PIX_W     = 8;
  localparam int COEF_W    = 32;
  localparam int REG_W     = 64;
  localparam int IDX_W     = 8;
  localparam int PROD_W    = 46;
  localparam int SUM_W     = 48;
  localparam int QW        = 12;
  localparam int DIV_W     = SUM_W + QW;
  localparam logic [PIX_W-1:0] LANE_VALUE = 8'd255;
  localparam logic [CW-1:0] GRID_ROWS_RESET = 12'd150;
  localparam logic [CW-1:0] GRID_COLS_RESET = 12'd300;

  typedef enum logic [IDX_W-1:0] {
    REG_ROW_NUM    = 8'd0,
    REG_COL_NUM    = 8'd1,
    REG_DENOM      = 8'd2,
    REG_NUM_CONST  = 8'd3,
    REG_DENOM_CONST = 8'd4,
    REG_GRID_ROWS  = 8'd5,
    REG_GRID_COLS  = 8'd6,
    REG_CROP_ROW   = 8'd7
  } reg_index_t;
endpackage
`default_nettype wire

FILE: src/ground_plane_pixel_remap.sv
// Top level of the ground plane pixel remap block.
`default_nettype none
// Maps lane-mask pixels onto a bird's-eye grid through a programmed homography.
// A pixel with value 255 at or below the crop start row is projected and, when
// the cell lies in the grid, one cell transaction is emitted. The pipeline takes
// one pixel per clock while not stalled, passing it through input, multiply,
// sum and magnitude stages, then twelve restoring divider stages (one quotient
// bit each, both quotients sharing the denominator), then the output register.
// The pipeline stalls as a whole when the output holds an untaken transaction.
module ground_plane_pixel_remap (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic [gppr_pkg::CW-1:0]    pixel_col,
  input  wire logic [gppr_pkg::CW-1:0]    pixel_row,
  input  wire logic [gppr_pkg::PIX_W-1:0] pixel_value,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic [gppr_pkg::CW-1:0]         cell_row,
  output logic [gppr_pkg::CW-1:0]         cell_col,
  input  wire logic                      cfg_valid,
  output logic                           cfg_ready,
  input  wire logic [gppr_pkg::IDX_W-1:0] cfg_index,
  input  wire logic [gppr_pkg::REG_W-1:0] cfg_data
);
  import gppr_pkg::*;

  logic [REG_W-1:0]         row_num_uv_coefs, col_num_uv_coefs, denom_uv_coefs;
  logic [REG_W-1:0]         num_constant_terms;
  logic signed [COEF_W-1:0] denom_constant_term;
  logic [CW-1:0]            grid_rows, grid_cols, crop_start_row;

  logic adv;
  assign adv       = !out_valid || out_ready;
  assign in_ready  = adv;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_num_uv_coefs    <= '0;
      col_num_uv_coefs    <= '0;
      denom_uv_coefs      <= '0;
      num_constant_terms  <= '0;
      denom_constant_term <= '0;
      grid_rows           <= GRID_ROWS_RESET;
      grid_cols           <= GRID_COLS_RESET;
      crop_start_row      <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_ROW_NUM:     row_num_uv_coefs    <= cfg_data;
        REG_COL_NUM:     col_num_uv_coefs    <= cfg_data;
        REG_DENOM:       denom_uv_coefs      <= cfg_data;
        REG_NUM_CONST:   num_constant_terms  <= cfg_data;
        REG_DENOM_CONST: denom_constant_term <= cfg_data[COEF_W-1:0];
        REG_GRID_ROWS:   grid_rows           <= cfg_data[CW-1:0];
        REG_GRID_COLS:   grid_cols           <= cfg_data[CW-1:0];
        REG_CROP_ROW:    crop_start_row      <= cfg_data[CW-1:0];
        default: ;
      endcase
    end
  end

  // Stage 1: qualify the pixel and form doubled centre coordinates.
  logic          s1_valid;
  logic [CW:0]   s1_u2, s1_v2;
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= in_valid && (pixel_value == LANE_VALUE) && (pixel_row >= crop_start_row);
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_u2 <= {pixel_col, 1'b1};
      s1_v2 <= {pixel_row, 1'b1};
    end
  end

  // Stage 2: six coefficient products.
  function automatic logic signed [PROD_W-1:0] mul_coef(input logic [COEF_W-1:0] c,
                                                        input logic [CW:0] x);
    logic signed [PROD_W-1:0] cx, xx;
    cx = PROD_W'($signed(c));
    xx = $signed({{(PROD_W-CW-1){1'b0}}, x});
    return cx * xx;
  endfunction

  logic                     s2_valid;
  logic signed [PROD_W-1:0] s2_ar, s2_br, s2_ac, s2_bc, s2_ad, s2_bd;
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (adv) begin
      s2_valid <= s1_valid;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      s2_ar <= mul_coef(row_num_uv_coefs[COEF_W-1:0], s1_u2);
      s2_br <= mul_coef(row_num_uv_coefs[REG_W-1:COEF_W], s1_v2);
      s2_ac <= mul_coef(col_num_uv_coefs[COEF_W-1:0], s1_u2);
      s2_bc <= mul_coef(col_num_uv_coefs[REG_W-1:COEF_W], s1_v2);
      s2_ad <= mul_coef(denom_uv_coefs[COEF_W-1:0], s1_u2);
      s2_bd <= mul_coef(denom_uv_coefs[REG_W-1:COEF_W], s1_v2);
    end
  end

  // Stage 3: linear forms.
  function automatic logic signed [SUM_W-1:0] lin(input logic signed [PROD_W-1:0] p,
                                                  input logic signed [PROD_W-1:0] q,
                                                  input logic [COEF_W-1:0] c);
    logic signed [SUM_W-1:0] c2;
    c2 = SUM_W'($signed({c, 1'b0}));
    return SUM_W'(p) + SUM_W'(q) + c2;
  endfunction

  logic                    s3_valid;
  logic signed [SUM_W-1:0] s3_nr, s3_nc, s3_d;
  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (adv) begin
      s3_valid <= s2_valid;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      s3_nr <= lin(s2_ar, s2_br, num_constant_terms[COEF_W-1:0]);
      s3_nc <= lin(s2_ac, s2_bc, num_constant_terms[REG_W-1:COEF_W]);
      s3_d  <= lin(s2_ad, s2_bd, denom_constant_term);
    end
  end

  // Stage 4: magnitudes, signs and early rejects; feeds divider slot 0.
  logic [SUM_W-1:0] mag_r, mag_c, mag_d;
  logic [DIV_W-1:0] ext_r, ext_c, ext_d, d_top;
  always_comb begin
    mag_r = s3_nr[SUM_W-1] ? SUM_W'(-s3_nr) : SUM_W'(s3_nr);
    mag_c = s3_nc[SUM_W-1] ? SUM_W'(-s3_nc) : SUM_W'(s3_nc);
    mag_d = s3_d[SUM_W-1]  ? SUM_W'(-s3_d)  : SUM_W'(s3_d);
    ext_r = {{QW{1'b0}}, mag_r};
    ext_c = {{QW{1'b0}}, mag_c};
    ext_d = {{QW{1'b0}}, mag_d};
    d_top = ext_d << QW;
  end

  logic             dv_valid [0:QW];
  logic [DIV_W-1:0] dv_rr [0:QW];
  logic [DIV_W-1:0] dv_rc [0:QW];
  logic [DIV_W-1:0] dv_d  [0:QW];
  logic [QW-1:0]    dv_qr [0:QW];
  logic [QW-1:0]    dv_qc [0:QW];
  logic             dv_negr [0:QW];
  logic             dv_negc [0:QW];

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_valid[0] <= 1'b0;
    end else if (adv) begin
      dv_valid[0] <= s3_valid && (mag_d != '0) && (ext_r < d_top) && (ext_c < d_top);
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      dv_rr[0]   <= ext_r;
      dv_rc[0]   <= ext_c;
      dv_d[0]    <= ext_d;
      dv_qr[0]   <= '0;
      dv_qc[0]   <= '0;
      dv_negr[0] <= s3_nr[SUM_W-1] ^ s3_d[SUM_W-1];
      dv_negc[0] <= s3_nc[SUM_W-1] ^ s3_d[SUM_W-1];
    end
  end

  // Restoring divider: slot k resolves quotient bit QW-1-k.
  for (genvar k = 0; k < QW; k++) begin : g_div
    logic [DIV_W-1:0] sh;
    logic             ge_r, ge_c;
    assign sh   = dv_d[k] << (QW - 1 - k);
    assign ge_r = dv_rr[k] >= sh;
    assign ge_c = dv_rc[k] >= sh;
    always_ff @(posedge clk) begin
      if (rst) begin
        dv_valid[k+1] <= 1'b0;
      end else if (adv) begin
        dv_valid[k+1] <= dv_valid[k];
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        dv_rr[k+1]   <= ge_r ? dv_rr[k] - sh : dv_rr[k];
        dv_rc[k+1]   <= ge_c ? dv_rc[k] - sh : dv_rc[k];
        dv_d[k+1]    <= dv_d[k];
        dv_qr[k+1]   <= dv_qr[k] | (QW'(ge_r) << (QW - 1 - k));
        dv_qc[k+1]   <= dv_qc[k] | (QW'(ge_c) << (QW - 1 - k));
        dv_negr[k+1] <= dv_negr[k];
        dv_negc[k+1] <= dv_negc[k];
      end
    end
  end

  // Output register: a negative nonzero quotient or one beyond the grid is dropped.
  logic hit;
  always_comb begin
    hit = dv_valid[QW]
       && !(dv_negr[QW] && (dv_qr[QW] != '0))
       && !(dv_negc[QW] && (dv_qc[QW] != '0))
       && (dv_qr[QW] < grid_rows) && (dv_qc[QW] < grid_cols);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= hit;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      cell_row <= dv_qr[QW];
      cell_col <= dv_qc[QW];
    end
  end
endmodule
`default_nettype wire

FILE: tb/ground_plane_pixel_remap_tb.sv
// Self-checking testbench for the ground plane pixel remap block.
`timescale 1ns / 100ps

module ground_plane_pixel_remap_tb;
  import gppr_pkg::*;

  typedef struct {
    logic [CW-1:0] row;
    logic [CW-1:0] col;
  } grid_cell_t;

  typedef enum int {
    SET_AFFINE,
    SET_PERSPECTIVE,
    SET_RANDOM,
    SET_ZERO_DENOM
  } setting_kind_t;

  class cell_scoreboard;
    logic [REG_W-1:0] row_coefs, col_coefs, den_coefs, num_consts;
    logic [COEF_W-1:0] den_const;
    logic [CW-1:0] grid_rows, grid_cols, crop_row;
    grid_cell_t cells_due[$];
    int errors;
    int cells_seen;
    int pixels_seen;

    function new();
      row_coefs = '0;
      col_coefs = '0;
      den_coefs = '0;
      num_consts = '0;
      den_const = '0;
      grid_rows = GRID_ROWS_RESET;
      grid_cols = GRID_COLS_RESET;
      crop_row = '0;
      errors = 0;
      cells_seen = 0;
      pixels_seen = 0;
    endfunction

    function void write_reg(logic [IDX_W-1:0] idx, logic [REG_W-1:0] data);
      case (idx)
        REG_ROW_NUM:     row_coefs = data;
        REG_COL_NUM:     col_coefs = data;
        REG_DENOM:       den_coefs = data;
        REG_NUM_CONST:   num_consts = data;
        REG_DENOM_CONST: den_const = data[COEF_W-1:0];
        REG_GRID_ROWS:   grid_rows = data[CW-1:0];
        REG_GRID_COLS:   grid_cols = data[CW-1:0];
        REG_CROP_ROW:    crop_row = data[CW-1:0];
        default: ;
      endcase
    endfunction

    function longint sx(logic [COEF_W-1:0] x);
      return longint'(signed'(x));
    endfunction

    function void note_pixel(logic [CW-1:0] pc, logic [CW-1:0] pr, logic [PIX_W-1:0] pv);
      longint u2, v2, nr, nc, d, qr, qc;
      grid_cell_t c;
      pixels_seen++;
      if (pv != LANE_VALUE || pr < crop_row) return;
      u2 = 2 * longint'(pc) + 1;
      v2 = 2 * longint'(pr) + 1;
      nr = sx(row_coefs[31:0]) * u2 + sx(row_coefs[63:32]) * v2 + 2 * sx(num_consts[31:0]);
      nc = sx(col_coefs[31:0]) * u2 + sx(col_coefs[63:32]) * v2 + 2 * sx(num_consts[63:32]);
      d = sx(den_coefs[31:0]) * u2 + sx(den_coefs[63:32]) * v2 + 2 * sx(den_const);
      if (d == 0) return;
      qr = nr / d;
      qc = nc / d;
      if (qr < 0 || qr >= longint'(grid_rows) || qc < 0 || qc >= longint'(grid_cols)) return;
      c.row = qr[CW-1:0];
      c.col = qc[CW-1:0];
      cells_due.push_back(c);
    endfunction

    function void check_cell(logic [CW-1:0] r, logic [CW-1:0] c);
      grid_cell_t e;
      cells_seen++;
      if (cells_due.size() == 0) begin
        $error("unexpected cell transaction row=%0d col=%0d", r, c);
        errors++;
        return;
      end
      e = cells_due.pop_front();
      if (r !== e.row) begin
        $error("cell_row mismatch: expected %0d, actual %0d", e.row, r);
        errors++;
      end
      if (c !== e.col) begin
        $error("cell_col mismatch: expected %0d, actual %0d", e.col, c);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [CW-1:0] pixel_col = '0;
  logic [CW-1:0] pixel_row = '0;
  logic [PIX_W-1:0] pixel_value = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [CW-1:0] cell_row;
  logic [CW-1:0] cell_col;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [IDX_W-1:0] cfg_index = '0;
  logic [REG_W-1:0] cfg_data = '0;

  cell_scoreboard sb = new();
  bit hold_request = 1'b0;
  bit no_idle = 1'b0;
  int cycle_count = 0;
  int settings_used = 0;
  localparam int CYCLE_LIMIT = 400000;

  ground_plane_pixel_remap DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .pixel_col(pixel_col), .pixel_row(pixel_row), .pixel_value(pixel_value),
    .out_valid(out_valid), .out_ready(out_ready),
    .cell_row(cell_row), .cell_col(cell_col),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (!rst) begin
      if (in_valid && in_ready) sb.note_pixel(pixel_col, pixel_row, pixel_value);
      if (out_valid && out_ready) sb.check_cell(cell_row, cell_col);
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
    end
    if (cycle_count > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    int r;
    out_ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      @(negedge clk);
      if (hold_request) begin
        out_ready = 1'b0;
        repeat (300) @(negedge clk);
        hold_request = 1'b0;
      end else if (no_idle) begin
        out_ready = 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        if (r == 99) begin
          out_ready = 1'b0;
          repeat ($urandom_range(20, 80)) @(negedge clk);
        end else begin
          out_ready = (r < 70);
        end
      end
    end
  end

  task automatic write_cfg(logic [IDX_W-1:0] idx, logic [REG_W-1:0] data);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic send_pixel(logic [CW-1:0] pc, logic [CW-1:0] pr, logic [PIX_W-1:0] pv);
    int gap;
    @(negedge clk);
    in_valid = 1'b1;
    pixel_col = pc;
    pixel_row = pr;
    pixel_value = pv;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (no_idle) gap = 0;
    else if ($urandom_range(0, 99) < 60) gap = 0;
    else if ($urandom_range(0, 99) < 95) gap = $urandom_range(1, 3);
    else gap = $urandom_range(20, 60);
    if (gap > 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (sb.cells_due.size() != 0) @(negedge clk);
    repeat (24) @(negedge clk);
  endtask

  task automatic apply_setting(setting_kind_t kind, logic [CW-1:0] rows,
                               logic [CW-1:0] cols, logic [CW-1:0] crop);
    int ar, br, ac, bc, ad, bd, cr, cc, cd;
    ad = 0; bd = 0;
    case (kind)
      SET_AFFINE: begin
        ar = $urandom_range(0, 8192) - 4096;
        br = $urandom_range(0, 8192) - 4096;
        ac = $urandom_range(0, 8192) - 4096;
        bc = $urandom_range(0, 8192) - 4096;
        cr = $urandom_range(0, 200) <<< 16;
        cc = $urandom_range(0, 300) <<< 16;
        cd = 32'h0001_0000;
      end
      SET_PERSPECTIVE: begin
        ar = $urandom_range(0, 16384) - 8192;
        br = $urandom_range(0, 65536);
        ac = $urandom_range(0, 65536) - 32768;
        bc = $urandom_range(0, 16384) - 8192;
        bd = $urandom_range(1, 64);
        cr = ($urandom_range(0, 400) - 200) <<< 16;
        cc = $urandom_range(0, 300) <<< 16;
        cd = $urandom_range(1, 4) <<< 16;
      end
      SET_RANDOM: begin
        ar = $urandom(); br = $urandom(); ac = $urandom(); bc = $urandom();
        ad = $urandom(); bd = $urandom(); cr = $urandom(); cc = $urandom();
        cd = $urandom();
      end
      default: begin
        ar = $urandom(); br = $urandom(); ac = $urandom(); bc = $urandom();
        cr = $urandom(); cc = $urandom(); cd = 0;
      end
    endcase
    write_cfg(REG_ROW_NUM, {br, ar});
    write_cfg(REG_COL_NUM, {bc, ac});
    write_cfg(REG_DENOM, {bd, ad});
    write_cfg(REG_NUM_CONST, {cc, cr});
    write_cfg(REG_DENOM_CONST, {32'($urandom()), cd});
    write_cfg(REG_GRID_ROWS, {52'($urandom()), rows});
    write_cfg(REG_GRID_COLS, {52'($urandom()), cols});
    write_cfg(REG_CROP_ROW, {52'($urandom()), crop});
    settings_used++;
  endtask

  task automatic random_pixels(int count, logic [CW-1:0] crop);
    logic [CW-1:0] pr;
    logic [PIX_W-1:0] pv;
    for (int i = 0; i < count; i++) begin
      if (i == count / 2 && settings_used == 1) hold_request = 1'b1;
      pv = ($urandom_range(0, 99) < 80) ? LANE_VALUE : PIX_W'($urandom());
      if ($urandom_range(0, 3) == 0 || crop == 0) pr = CW'($urandom());
      else pr = CW'($urandom_range(crop, 4095));
      send_pixel(CW'($urandom()), pr, pv);
    end
  endtask

  initial begin
    setting_kind_t kind;
    logic [CW-1:0] crop;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Reset state: all coefficients zero, so every denominator is zero.
    send_pixel(12'd0, 12'd0, LANE_VALUE);
    send_pixel(12'd4095, 12'd4095, LANE_VALUE);
    drain();

    // Constant denominator of 1.0 with a row offset of -0.5 truncates to row 0.
    write_cfg(REG_ROW_NUM, 64'd0);
    write_cfg(REG_COL_NUM, {32'h0000_0000, 32'h0000_8000});
    write_cfg(REG_DENOM, 64'd0);
    write_cfg(REG_NUM_CONST, {32'h0002_0000, 32'hFFFF_8000});
    write_cfg(REG_DENOM_CONST, 64'h0000_0000_0001_0000);
    write_cfg(REG_GRID_ROWS, 64'd4095);
    write_cfg(REG_GRID_COLS, 64'd4095);
    write_cfg(REG_CROP_ROW, 64'd100);
    write_cfg(8'd8, 64'd0);
    write_cfg(8'd255, 64'hFFFF_FFFF_FFFF_FFFF);
    send_pixel(12'd0, 12'd100, LANE_VALUE);
    send_pixel(12'd4095, 12'd4095, LANE_VALUE);
    send_pixel(12'd10, 12'd99, LANE_VALUE);
    send_pixel(12'd10, 12'd0, LANE_VALUE);
    send_pixel(12'd10, 12'd200, 8'd254);
    send_pixel(12'd10, 12'd200, 8'd0);
    send_pixel(12'd2000, 12'd3000, LANE_VALUE);
    drain();

    // Grid of one cell, then an empty grid.
    write_cfg(REG_GRID_ROWS, 64'd1);
    write_cfg(REG_GRID_COLS, 64'd1);
    write_cfg(REG_CROP_ROW, 64'd0);
    send_pixel(12'd0, 12'd0, LANE_VALUE);
    send_pixel(12'd1, 12'd0, LANE_VALUE);
    send_pixel(12'd4095, 12'd0, LANE_VALUE);
    drain();
    write_cfg(REG_GRID_ROWS, 64'd0);
    send_pixel(12'd0, 12'd0, LANE_VALUE);
    drain();
    write_cfg(REG_CROP_ROW, 64'd4095);
    send_pixel(12'd0, 12'd4094, LANE_VALUE);
    send_pixel(12'd0, 12'd4095, LANE_VALUE);
    drain();

    for (int p = 0; p < 9; p++) begin
      case (p % 4)
        0, 2: kind = SET_AFFINE;
        1: kind = SET_PERSPECTIVE;
        default: kind = (p == 3) ? SET_ZERO_DENOM : SET_RANDOM;
      endcase
      crop = (p == 5) ? CW'(4095) : (p % 3 == 0) ? CW'(0) : CW'($urandom_range(0, 3000));
      no_idle = (p == 6);
      apply_setting(kind, (p == 7) ? CW'(4095) : CW'($urandom_range(1, 400)),
                    (p == 7) ? CW'(4095) : CW'($urandom_range(1, 400)), crop);
      random_pixels(205, crop);
      drain();
    end
    no_idle = 1'b0;
    repeat (40) @(posedge clk);

    $display("Covered %0d pixels over %0d register settings, %0d cells checked.",
             sb.pixels_seen, settings_used, sb.cells_seen);
    if (sb.errors == 0 && sb.cells_due.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      if (sb.cells_due.size() != 0)
        $error("%0d expected cells never arrived", sb.cells_due.size());
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
